// File: rtl/tkp_pkg.sv
// shared types, constants and helpers for the top-k / top-p token sampler
// no dependencies
package tkp_pkg;

    localparam int VOCAB_MAX_DEF      = 32768;
    localparam int WINDOW_DEF         = 64;
    localparam int TOPK_MAX_DEF       = 64;
    localparam int EXP_TABLE_SIZE_DEF = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // opcodes of an input word
    localparam logic OP_RECENT = 1'b0;
    localparam logic OP_LOGIT  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASS_CUTOFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TEMP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY_RECP = 3'd4;

    localparam logic [6:0]  KEEP_COUNT_RST   = 7'd40;
    localparam logic [16:0] MASS_CUTOFF_RST  = 17'd62259;
    localparam logic [15:0] INV_TEMP_RST     = 16'd4096;
    localparam logic [15:0] PENALTY_RST      = 16'd4096;
    localparam logic [15:0] PENALTY_RECP_RST = 16'd4096;

    typedef struct packed {
        logic               opcode;
        logic [14:0]        token_value;
        logic signed [23:0] score;
        logic               final_logit;
        logic [15:0]        uniform_draw;
    } req_t;

    typedef struct packed {
        logic [14:0] chosen_token;
        logic [6:0]  candidates_kept;
        logic        status;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic scale;
        logic pen;
        logic ins;
        logic w_fetch;
        logic w_rom;
        logic w_acc;
        logic c_start;
        logic c_rd;
        logic c_acc;
        logic d_start;
        logic d_rd;
        logic d_acc;
        logic id_rd;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_final;
        logic w_last;
        logic no_cut;
        logic cut_hit;
        logic draw_hit;
        logic draw_last;
        logic out_free;
        logic fill_empty;
    } sts_t;

    // q8.16 times q4.12 product, round half up, saturate to 24 bits
    function automatic logic signed [23:0] rnd_sat(input logic signed [40:0] p);
        logic signed [40:0] t;
        t = (p + 41'sd2048) >>> 12;
        if (t > 41'sd8388607) begin
            return 24'sh7FFFFF;
        end
        if (t < -41'sd8388608) begin
            return 24'sh800000;
        end
        return t[23:0];
    endfunction

endpackage

// File: rtl/top_k_top_p_token_sampler.sv
// a recent token word is taken while idle; a logit word steps through the scale multiply,
// the penalty multiply and the insert into the sorted store
// the final logit then adds a weight pass over the kept entries, the top-p cut scan, the
// draw scan, an id read and the emit, which waits while an older result is held
// one word at a time; the result register lets the next word in while a result waits
// reset: asynchronous active low, clears all round state and loads register defaults
module top_k_top_p_token_sampler #(
    parameter int VOCAB_MAX      = tkp_pkg::VOCAB_MAX_DEF,
    parameter int WINDOW         = tkp_pkg::WINDOW_DEF,
    parameter int TOPK_MAX       = tkp_pkg::TOPK_MAX_DEF,
    parameter int EXP_TABLE_SIZE = tkp_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tkp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tkp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  tkp_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output tkp_pkg::rsp_t                  rsp
);
    import tkp_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;

    // sequencer walks the passes, the datapath holds all storage
    tkp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .sts        (sts),
        .cmd        (cmd),
        .busy       (busy)
    );

    tkp_datapath #(
        .VOCAB_MAX      (VOCAB_MAX),
        .WINDOW         (WINDOW),
        .TOPK_MAX       (TOPK_MAX),
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // a word is taken only while the sequencer is idle
    assign req_stall = busy;

`ifndef SYNTH
    // a logit word keeps the sequencer busy on the next cycle
    a_logit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.opcode == OP_LOGIT |=> req_stall)
        else $error("logit word did not start the insert sequence");

    // a new result always comes with the round state cleared
    a_round_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> sts.fill_empty)
        else $error("round state not cleared after result");
`endif

endmodule

// File: rtl/tkp_ctrl.sv
// sequencer of the token sampler: insert, weight, cut and draw passes
// depends on tkp_pkg
module tkp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_opcode,
    input  tkp_pkg::sts_t sts,
    output tkp_pkg::cmd_t cmd,
    output logic          busy
);
    import tkp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCALE, ST_PEN, ST_INS,
        ST_WFETCH, ST_WROM, ST_WACC,
        ST_CSTART, ST_CRD, ST_CACC,
        ST_DSTART, ST_DRD, ST_DACC,
        ST_IDRD, ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = req_valid;
                if (req_valid && req_opcode == OP_LOGIT)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_PEN;
            end
            ST_PEN:
            begin
                cmd.pen    = 1'b1;
                state_next = ST_INS;
            end
            ST_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = sts.is_final ? ST_WFETCH : ST_IDLE;
            end
            ST_WFETCH:
            begin
                cmd.w_fetch = 1'b1;
                state_next  = ST_WROM;
            end
            ST_WROM:
            begin
                cmd.w_rom  = 1'b1;
                state_next = ST_WACC;
            end
            ST_WACC:
            begin
                cmd.w_acc  = 1'b1;
                state_next = sts.w_last ? ST_CSTART : ST_WFETCH;
            end
            ST_CSTART:
            begin
                cmd.c_start = 1'b1;
                state_next  = sts.no_cut ? ST_DSTART : ST_CRD;
            end
            ST_CRD:
            begin
                cmd.c_rd   = 1'b1;
                state_next = ST_CACC;
            end
            ST_CACC:
            begin
                cmd.c_acc  = 1'b1;
                state_next = sts.cut_hit ? ST_DSTART : ST_CRD;
            end
            ST_DSTART:
            begin
                cmd.d_start = 1'b1;
                state_next  = ST_DRD;
            end
            ST_DRD:
            begin
                cmd.d_rd   = 1'b1;
                state_next = ST_DACC;
            end
            ST_DACC:
            begin
                cmd.d_acc  = 1'b1;
                state_next = (sts.draw_hit || sts.draw_last) ? ST_IDRD : ST_DRD;
            end
            ST_IDRD:
            begin
                cmd.id_rd  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: rtl/tkp_datapath.sv
// datapath of the token sampler: registers, recent cam, sorted store,
// exp table, weight and id memories, result register; depends on tkp_pkg
module tkp_datapath #(
    parameter int VOCAB_MAX      = tkp_pkg::VOCAB_MAX_DEF,
    parameter int WINDOW         = tkp_pkg::WINDOW_DEF,
    parameter int TOPK_MAX       = tkp_pkg::TOPK_MAX_DEF,
    parameter int EXP_TABLE_SIZE = tkp_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tkp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tkp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  tkp_pkg::req_t                    req,
    input  tkp_pkg::cmd_t                    cmd,
    output tkp_pkg::sts_t                    sts,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output tkp_pkg::rsp_t                    rsp
);
    import tkp_pkg::*;

    localparam int IDX_W = $clog2(VOCAB_MAX);
    localparam int K_W   = $clog2(TOPK_MAX + 1);
    localparam int KI_W  = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;
    localparam int RF_W  = $clog2(WINDOW + 1);
    localparam int RI_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TBL_W = $clog2(EXP_TABLE_SIZE);
    localparam int W_W   = 17;
    localparam int SUM_W = W_W + K_W;

    typedef logic [W_W-1:0] rom_t [EXP_TABLE_SIZE];

    // exp(-16 i / size) in q1.16 built at elaboration
    function automatic rom_t build_rom();
        rom_t                r;
        logic [63:0]         f;
        logic [63:0]         term;
        logic [63:0]         v;
        logic signed [65:0]  sum;
        r[0] = 17'd65536;
        for (int i = 1; i < EXP_TABLE_SIZE; i++)
        begin
            f    = (64'(i) << 32) / EXP_TABLE_SIZE;
            term = 64'd1 << 32;
            sum  = 66'sd4294967296;
            for (int k = 1; k <= 20; k++)
            begin
                term = ((term * f) >> 32) / 64'(k);
                if (k % 2 == 1)
                begin
                    sum = sum - $signed({2'b0, term});
                end
                else
                begin
                    sum = sum + $signed({2'b0, term});
                end
            end
            if (sum < 0)
            begin
                sum = '0;
            end
            if (sum > 66'sd4294967295)
            begin
                sum = 66'sd4294967295;
            end
            v = 64'(sum);
            for (int k = 0; k < 4; k++)
            begin
                v = (v * v) >> 32;
            end
            r[i] = W_W'((v + 64'd32768) >> 16);
        end
        return r;
    endfunction

    localparam rom_t EXP_ROM = build_rom();

    // configuration
    logic [6:0]  keep_count_reg;
    logic [16:0] mass_cutoff_reg;
    logic [15:0] inv_temp_reg, penalty_reg, penalty_recp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg   <= KEEP_COUNT_RST;
            mass_cutoff_reg  <= MASS_CUTOFF_RST;
            inv_temp_reg     <= INV_TEMP_RST;
            penalty_reg      <= PENALTY_RST;
            penalty_recp_reg <= PENALTY_RECP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEEP_COUNT:   keep_count_reg   <= cfg_data[6:0];
                REG_MASS_CUTOFF:  mass_cutoff_reg  <= cfg_data;
                REG_INV_TEMP:     inv_temp_reg     <= cfg_data[15:0];
                REG_PENALTY:      penalty_reg      <= cfg_data[15:0];
                REG_PENALTY_RECP: penalty_recp_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // round control
    logic [RF_W-1:0]  recent_fill_reg;
    logic             overflow_reg;
    logic [IDX_W-1:0] next_index_reg;
    logic [K_W-1:0]   best_fill_reg, best_fill_next;
    logic [K_W-1:0]   cnt_reg;
    logic [K_W-1:0]   kept_reg;
    logic [KI_W-1:0]  pick_reg;
    logic             out_free;

    // payload
    req_t                    in_reg;
    logic [14:0]             recent_reg [WINDOW];
    logic signed [23:0]      best_s_reg [TOPK_MAX];
    logic [IDX_W-1:0]        best_id_reg [TOPK_MAX];
    logic [W_W-1:0]          w_mem [TOPK_MAX];
    logic [IDX_W-1:0]        id_mem [TOPK_MAX];
    logic signed [40:0]      prod1_reg, prod2_reg;
    logic signed [23:0]      s1_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        id_reg;
    logic signed [23:0]      max_reg;
    logic [TBL_W-1:0]        idx_reg;
    logic                    oob_reg;
    logic [W_W-1:0]          rom_q, w_q;
    logic [IDX_W-1:0]        id_q;
    logic [SUM_W-1:0]        total_reg, cum_reg, ksum_reg, target_reg;
    logic [SUM_W+16:0]       thr_reg;

    // recent token lookup, one comparator per entry
    logic [IDX_W+14:0] id_wide;
    logic [14:0]       id15;
    logic              recent_hit;

    assign id_wide = {15'b0, next_index_reg};
    assign id15    = id_wide[14:0];

    always_comb
    begin
        recent_hit = 1'b0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if (RF_W'(j) < recent_fill_reg && recent_reg[j] == id15)
            begin
                recent_hit = 1'b1;
            end
        end
    end

    // penalty stage
    logic signed [23:0] s1;
    logic signed [23:0] s_new;

    assign s1    = rnd_sat(prod1_reg);
    assign s_new = hit_reg ? rnd_sat(prod2_reg) : s1_reg;

    // sorted insertion
    logic [K_W-1:0]      k_eff, fill_eff;
    logic [TOPK_MAX-1:0] b;
    logic                ins_ok;

    always_comb
    begin
        if (keep_count_reg == 7'd0)
        begin
            k_eff = K_W'(1);
        end
        else if (int'(keep_count_reg) > TOPK_MAX)
        begin
            k_eff = K_W'(TOPK_MAX);
        end
        else
        begin
            k_eff = K_W'(keep_count_reg);
        end
        fill_eff = (best_fill_reg > k_eff) ? k_eff : best_fill_reg;
        ins_ok   = 1'b0;
        for (int j = 0; j < TOPK_MAX; j++)
        begin
            b[j] = (K_W'(j) >= fill_eff) || (s_new > best_s_reg[j]) ||
                   (s_new == best_s_reg[j] && id_reg < best_id_reg[j]);
            if (K_W'(j) < k_eff && b[j])
            begin
                ins_ok = 1'b1;
            end
        end
        if (ins_ok && fill_eff < k_eff)
        begin
            best_fill_next = fill_eff + K_W'(1);
        end
        else
        begin
            best_fill_next = fill_eff;
        end
    end

    // weight index
    logic signed [23:0] max_now;
    logic [23:0]        diff;
    logic [36:0]        idx_prod;
    logic [16:0]        idx_full;

    assign max_now  = (cnt_reg == '0) ? best_s_reg[0] : max_reg;
    assign diff     = 24'(max_now - best_s_reg[0]);
    assign idx_prod = {13'b0, diff} * 37'(EXP_TABLE_SIZE);
    assign idx_full = idx_prod[36:20];

    // cut and draw sums
    logic [SUM_W-1:0]  cum_n;
    logic [SUM_W+16:0] cum_sh;
    logic [SUM_W+15:0] tgt_prod;

    assign cum_n    = cum_reg + SUM_W'(w_q);
    assign cum_sh   = {1'b0, cum_n, 16'b0};
    assign tgt_prod = in_reg.uniform_draw * ksum_reg;

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_reg <= req;
            if (req.opcode == OP_RECENT && recent_fill_reg < RF_W'(WINDOW))
            begin
                recent_reg[recent_fill_reg[RI_W-1:0]] <= req.token_value;
            end
        end
        if (cmd.scale)
        begin
            prod1_reg <= in_reg.score * $signed({1'b0, inv_temp_reg});
            id_reg    <= next_index_reg;
            hit_reg   <= recent_hit;
        end
        if (cmd.pen)
        begin
            s1_reg    <= s1;
            prod2_reg <= s1 * $signed({1'b0, (s1 < 0) ? penalty_reg : penalty_recp_reg});
        end
        if (cmd.ins && ins_ok)
        begin
            for (int j = 0; j < TOPK_MAX; j++)
            begin
                if (j > 0 && b[(j > 0) ? j - 1 : 0])
                begin
                    best_s_reg[j]  <= best_s_reg[(j > 0) ? j - 1 : 0];
                    best_id_reg[j] <= best_id_reg[(j > 0) ? j - 1 : 0];
                end
                else if (b[j])
                begin
                    best_s_reg[j]  <= s_new;
                    best_id_reg[j] <= id_reg;
                end
            end
        end
        if (cmd.w_fetch)
        begin
            // pop the head of the sorted store
            max_reg                 <= max_now;
            idx_reg                 <= idx_full[TBL_W-1:0];
            oob_reg                 <= (int'(idx_full) >= EXP_TABLE_SIZE);
            id_mem[cnt_reg[KI_W-1:0]] <= best_id_reg[0];
            for (int j = 0; j < TOPK_MAX - 1; j++)
            begin
                best_s_reg[j]  <= best_s_reg[j + 1];
                best_id_reg[j] <= best_id_reg[j + 1];
            end
        end
        if (cmd.w_rom)
        begin
            rom_q <= EXP_ROM[idx_reg];
        end
        if (cmd.w_acc)
        begin
            w_mem[cnt_reg[KI_W-1:0]] <= oob_reg ? '0 : rom_q;
        end
        if (cmd.c_rd || cmd.d_rd)
        begin
            w_q <= w_mem[cnt_reg[KI_W-1:0]];
        end
        if (cmd.c_start)
        begin
            thr_reg  <= mass_cutoff_reg * total_reg;
            ksum_reg <= total_reg;
        end
        if (cmd.c_acc && sts.cut_hit)
        begin
            ksum_reg <= cum_n;
        end
        if (cmd.d_start)
        begin
            target_reg <= tgt_prod[SUM_W+15:16];
        end
        if (cmd.d_acc)
        begin
            pick_reg <= sts.draw_hit ? cnt_reg[KI_W-1:0] : '0;
        end
        if (cmd.id_rd)
        begin
            id_q <= id_mem[pick_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_fill_reg <= '0;
            overflow_reg    <= 1'b0;
            next_index_reg  <= '0;
            best_fill_reg   <= '0;
            cnt_reg         <= '0;
            kept_reg        <= '0;
            total_reg       <= '0;
            cum_reg         <= '0;
        end
        else
        begin
            if (cmd.accept && req.opcode == OP_RECENT)
            begin
                if (recent_fill_reg < RF_W'(WINDOW))
                begin
                    recent_fill_reg <= recent_fill_reg + RF_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.scale)
            begin
                next_index_reg <= (next_index_reg == IDX_W'(VOCAB_MAX - 1)) ?
                                  '0 : next_index_reg + IDX_W'(1);
            end
            if (cmd.ins)
            begin
                best_fill_reg <= best_fill_next;
                cnt_reg       <= '0;
                total_reg     <= '0;
            end
            if (cmd.w_acc)
            begin
                total_reg <= total_reg + SUM_W'(oob_reg ? '0 : rom_q);
                cnt_reg   <= cnt_reg + K_W'(1);
            end
            if (cmd.c_start || cmd.d_start)
            begin
                cnt_reg <= '0;
                cum_reg <= '0;
            end
            if (cmd.c_start)
            begin
                kept_reg <= best_fill_reg;
            end
            if (cmd.c_acc)
            begin
                cum_reg <= cum_n;
                if (sts.cut_hit)
                begin
                    kept_reg <= cnt_reg + K_W'(1);
                end
                else
                begin
                    cnt_reg <= cnt_reg + K_W'(1);
                end
            end
            if (cmd.d_acc)
            begin
                cum_reg <= cum_n;
                cnt_reg <= cnt_reg + K_W'(1);
            end
            if (cmd.emit)
            begin
                // round done, clear for the next one
                recent_fill_reg <= '0;
                overflow_reg    <= 1'b0;
                next_index_reg  <= '0;
                best_fill_reg   <= '0;
            end
        end
    end

    // result register
    logic [IDX_W+14:0] pick_wide;
    assign pick_wide = {15'b0, id_q};
    assign out_free  = !rsp_valid || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp.chosen_token    <= pick_wide[14:0];
            rsp.candidates_kept <= 7'(kept_reg);
            rsp.status          <= overflow_reg;
        end
    end

    always_comb
    begin
        sts.is_final   = in_reg.final_logit;
        sts.w_last     = (cnt_reg == best_fill_reg - K_W'(1));
        sts.no_cut     = mass_cutoff_reg[16];
        sts.cut_hit    = (cum_sh >= thr_reg);
        sts.draw_hit   = (cum_n > target_reg);
        sts.draw_last  = (cnt_reg == kept_reg - K_W'(1));
        sts.out_free   = out_free;
        sts.fill_empty = (best_fill_reg == '0) && (recent_fill_reg == '0);
    end

endmodule
